>>> hw/rtl/srs_pkg.sv
`timescale 1ns / 1ps

package srs_pkg;

   // Default sizes
   localparam int RING_BYTES_DEF      = 16384;
   localparam int MAX_FRAME_BYTES_DEF = 1600;

   // Item kinds
   typedef enum logic [1:0] {
      KIND_SELECT = 2'd0,
      KIND_SPI    = 2'd1,
      KIND_NET    = 2'd2,
      KIND_DRAIN  = 2'd3
   } kind_type;

   // Block select codes
   localparam logic [4:0] BLK_COMMON = 5'd0;
   localparam logic [4:0] BLK_SOCKET = 5'd1;
   localparam logic [4:0] BLK_TXRING = 5'd2;
   localparam logic [4:0] BLK_RXRING = 5'd3;

   // Common register map
   localparam logic [15:0] REG_MR       = 16'h0000;
   localparam logic [15:0] REG_SHAR     = 16'h0009;
   localparam logic [15:0] REG_VERSION  = 16'h0039;
   localparam logic [7:0]  VERSION_CODE = 8'h04;
   localparam logic [7:0]  MR_RESET_BIT = 8'h80;

   // Socket register map
   localparam logic [15:0] SREG_MODE     = 16'h0000;
   localparam logic [15:0] SREG_CMD      = 16'h0001;
   localparam logic [15:0] SREG_STATUS   = 16'h0003;
   localparam logic [15:0] SREG_TXFREE_H = 16'h0020;
   localparam logic [15:0] SREG_TXFREE_L = 16'h0021;
   localparam logic [15:0] SREG_TXRD_H   = 16'h0022;
   localparam logic [15:0] SREG_TXRD_L   = 16'h0023;
   localparam logic [15:0] SREG_TXWR_H   = 16'h0024;
   localparam logic [15:0] SREG_TXWR_L   = 16'h0025;
   localparam logic [15:0] SREG_RXSIZE_H = 16'h0026;
   localparam logic [15:0] SREG_RXSIZE_L = 16'h0027;
   localparam logic [15:0] SREG_RXRD_H   = 16'h0028;
   localparam logic [15:0] SREG_RXRD_L   = 16'h0029;
   localparam logic [15:0] SREG_RXWR_H   = 16'h002A;
   localparam logic [15:0] SREG_RXWR_L   = 16'h002B;

   // Socket commands and codes
   localparam logic [7:0] SOCK_OPEN   = 8'h01;
   localparam logic [7:0] SOCK_CLOSE  = 8'h10;
   localparam logic [7:0] SOCK_XMIT   = 8'h20;
   localparam logic [3:0] MODE_RAW    = 4'h4;
   localparam logic [7:0] STATUS_RAW  = 8'h42;
   localparam logic [7:0] STATUS_NONE = 8'h00;
   localparam logic [7:0] IDLE_BYTE   = 8'hFF;

   typedef struct packed {
      kind_type   kind;
      logic       select_level;
      logic [7:0] spi_in;
      logic [7:0] net_byte;
      logic       net_last;
   } item_type;

   typedef struct packed {
      logic [7:0] spi_out;
      logic       spi_from_mem;
      logic       tx_valid;
      logic       tx_last;
      logic       rx_dropped;
   } result_type;

   typedef struct packed {
      logic        wr_en;
      logic        rd_en;
      logic [15:0] addr;
      logic [7:0]  wdata;
   } mem_req_type;

endpackage

>>> hw/rtl/srs_ring.sv
`timescale 1ns / 1ps

module srs_ring import srs_pkg::*; #(
   parameter int DEPTH = RING_BYTES_DEF
) (
   input  logic        clock,
   input  mem_req_type req,
   output logic [7:0]  rd_data
);

   localparam int AW = $clog2(DEPTH);

   logic [7:0]    mem [DEPTH];
   logic [7:0]    rd_data_ff;
   logic [AW-1:0] idx;

   assign idx     = req.addr[AW-1:0];
   assign rd_data = rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[idx] <= req.wdata;
      end
      if (req.rd_en) begin
         rd_data_ff <= mem[idx];
      end
   end

endmodule

>>> hw/rtl/srs_core.sv
`timescale 1ns / 1ps

module srs_core import srs_pkg::*; #(
   parameter int RING_BYTES      = RING_BYTES_DEF,
   parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        fire,
   input  item_type    item,
   output result_type  res,
   output mem_req_type tx_req,
   output mem_req_type rx_req,
   output logic        busy
);

   localparam logic [16:0] RING_SIZE = 17'(RING_BYTES);
   localparam logic [10:0] MAX_FRAME = 11'(MAX_FRAME_BYTES);

   logic        sel_ff, sel_in;
   logic [1:0]  phase_ff, phase_in;
   logic [15:0] addr_ff, addr_in;
   logic [4:0]  blk_ff, blk_in;
   logic        wr_ff, wr_in;
   logic [7:0]  station_ff [6];
   logic [7:0]  station_in [6];
   logic [7:0]  smode_ff, smode_in;
   logic [7:0]  sstat_ff, sstat_in;
   logic [15:0] txwr_ff, txwr_in;
   logic [15:0] txrd_ff, txrd_in;
   logic [15:0] rxwr_ff, rxwr_in;
   logic [15:0] rxrd_ff, rxrd_in;
   logic [10:0] acount_ff, acount_in;
   logic        afits_ff, afits_in;
   logic [15:0] dpos_ff, dpos_in;
   logic [10:0] drem_ff, drem_in;
   logic [1:0]  hcnt_ff, hcnt_in;
   logic [15:0] haddr_ff, haddr_in;
   logic [15:0] hlen_ff, hlen_in;

   logic [15:0] tx_used, tx_free, rx_used, sta_off, need;
   logic [16:0] room;
   logic [7:0]  rd_val, v;
   logic        sw_reset;
   mem_req_type rx_item_req;

   assign v       = item.spi_in;
   assign tx_used = txwr_ff - txrd_ff;
   assign tx_free = 16'(RING_BYTES) - tx_used;
   assign rx_used = rxwr_ff - rxrd_ff;
   assign room    = ({1'b0, rx_used} >= RING_SIZE) ? 17'd0 : RING_SIZE - {1'b0, rx_used};
   assign sta_off = addr_ff - REG_SHAR;
   assign busy    = (hcnt_ff != 2'd0);

   // Register read mux
   always_comb begin
      rd_val = 8'h00;
      if (blk_ff == BLK_COMMON) begin
         if (addr_ff == REG_VERSION) begin
            rd_val = VERSION_CODE;
         end else if (addr_ff >= REG_SHAR && addr_ff < REG_SHAR + 16'd6) begin
            rd_val = station_ff[sta_off[2:0]];
         end
      end else if (blk_ff == BLK_SOCKET) begin
         unique case (addr_ff)
            SREG_MODE:     rd_val = smode_ff;
            SREG_STATUS:   rd_val = sstat_ff;
            SREG_TXFREE_H: rd_val = tx_free[15:8];
            SREG_TXFREE_L: rd_val = tx_free[7:0];
            SREG_TXRD_H:   rd_val = txrd_ff[15:8];
            SREG_TXRD_L:   rd_val = txrd_ff[7:0];
            SREG_TXWR_H:   rd_val = txwr_ff[15:8];
            SREG_TXWR_L:   rd_val = txwr_ff[7:0];
            SREG_RXSIZE_H: rd_val = rx_used[15:8];
            SREG_RXSIZE_L: rd_val = rx_used[7:0];
            SREG_RXRD_H:   rd_val = rxrd_ff[15:8];
            SREG_RXRD_L:   rd_val = rxrd_ff[7:0];
            SREG_RXWR_H:   rd_val = rxwr_ff[15:8];
            SREG_RXWR_L:   rd_val = rxwr_ff[7:0];
            default:       rd_val = 8'h00;
         endcase
      end
   end

   // Next state for one item
   always_comb begin
      sel_in     = sel_ff;
      phase_in   = phase_ff;
      addr_in    = addr_ff;
      blk_in     = blk_ff;
      wr_in      = wr_ff;
      station_in = station_ff;
      smode_in   = smode_ff;
      sstat_in   = sstat_ff;
      txwr_in    = txwr_ff;
      txrd_in    = txrd_ff;
      rxwr_in    = rxwr_ff;
      rxrd_in    = rxrd_ff;
      acount_in  = acount_ff;
      afits_in   = afits_ff;
      dpos_in    = dpos_ff;
      drem_in    = drem_ff;
      hcnt_in    = busy ? hcnt_ff - 2'd1 : hcnt_ff;
      haddr_in   = haddr_ff;
      hlen_in    = hlen_ff;
      sw_reset   = 1'b0;
      need       = 16'(acount_ff) + 16'd2;
      res        = '{spi_out: IDLE_BYTE, default: '0};
      tx_req     = '{default: '0};
      rx_item_req = '{default: '0};

      if (fire) begin
         unique case (item.kind)
            KIND_SELECT: begin
               if (item.select_level && !sel_ff) begin
                  phase_in = 2'd0;
               end
               sel_in = item.select_level;
            end
            KIND_SPI: begin
               if (sel_ff) begin
                  unique case (phase_ff)
                     2'd0: begin
                        addr_in  = {v, 8'h00};
                        phase_in = 2'd1;
                     end
                     2'd1: begin
                        addr_in  = addr_ff | {8'h00, v};
                        phase_in = 2'd2;
                     end
                     2'd2: begin
                        blk_in   = v[7:3];
                        wr_in    = v[2];
                        phase_in = 2'd3;
                     end
                     default: begin
                        if (wr_ff) begin
                           if (blk_ff == BLK_TXRING) begin
                              tx_req = '{wr_en: 1'b1, rd_en: 1'b0, addr: addr_ff, wdata: v};
                           end else if (blk_ff == BLK_COMMON) begin
                              if (addr_ff == REG_MR && (v & MR_RESET_BIT) != 8'h00) begin
                                 sw_reset = 1'b1;
                              end else if (addr_ff >= REG_SHAR
                                           && addr_ff < REG_SHAR + 16'd6) begin
                                 station_in[sta_off[2:0]] = v;
                              end
                           end else if (blk_ff == BLK_SOCKET) begin
                              case (addr_ff)
                                 SREG_MODE: smode_in = v;
                                 SREG_CMD: begin
                                    if (v == SOCK_OPEN) begin
                                       sstat_in = (smode_ff[3:0] == MODE_RAW) ?
                                                  STATUS_RAW : STATUS_NONE;
                                    end else if (v == SOCK_CLOSE) begin
                                       sstat_in = STATUS_NONE;
                                    end else if (v == SOCK_XMIT) begin
                                       if (tx_used != 16'd0 && tx_used <= 16'(MAX_FRAME_BYTES)) begin
                                          dpos_in = txrd_ff;
                                          drem_in = tx_used[10:0];
                                       end
                                       txrd_in = txwr_ff;
                                    end
                                 end
                                 SREG_TXWR_H: txwr_in = {v, txwr_ff[7:0]};
                                 SREG_TXWR_L: txwr_in = {txwr_ff[15:8], v};
                                 SREG_RXRD_H: rxrd_in = {v, rxrd_ff[7:0]};
                                 SREG_RXRD_L: rxrd_in = {rxrd_ff[15:8], v};
                                 default: ;
                              endcase
                           end
                        end else begin
                           if (blk_ff == BLK_RXRING) begin
                              rx_item_req = '{wr_en: 1'b0, rd_en: 1'b1, addr: addr_ff,
                                              wdata: 8'h00};
                              res.spi_from_mem = 1'b1;
                           end else begin
                              res.spi_out = rd_val;
                           end
                        end
                        addr_in = addr_ff + 16'd1;
                        // soft reset clears the transaction, socket state and ring pointers
                        if (sw_reset) begin
                           sel_in    = 1'b0;
                           phase_in  = 2'd0;
                           blk_in    = BLK_COMMON;
                           wr_in     = 1'b0;
                           addr_in   = 16'd1;
                           smode_in  = 8'h00;
                           sstat_in  = STATUS_NONE;
                           txwr_in   = 16'd0;
                           txrd_in   = 16'd0;
                           rxwr_in   = 16'd0;
                           rxrd_in   = 16'd0;
                           afits_in  = afits_ff && (acount_ff == 11'd0);
                           acount_in = 11'd0;
                        end
                     end
                  endcase
               end
            end
            KIND_NET: begin
               if (afits_ff) begin
                  if (acount_ff >= MAX_FRAME || 17'(acount_ff) + 17'd3 > room) begin
                     afits_in = 1'b0;
                  end else begin
                     rx_item_req = '{wr_en: 1'b1, rd_en: 1'b0,
                                     addr: rxwr_ff + 16'd2 + 16'(acount_ff),
                                     wdata: item.net_byte};
                     acount_in = acount_ff + 11'd1;
                  end
               end
               if (item.net_last) begin
                  // publish: length prefix goes out through the RX port while busy, high byte first
                  if (afits_in) begin
                     need     = 16'(acount_in) + 16'd2;
                     hcnt_in  = 2'd2;
                     haddr_in = rxwr_ff;
                     hlen_in  = need;
                     rxwr_in  = rxwr_ff + need;
                  end else begin
                     res.rx_dropped = 1'b1;
                  end
                  acount_in = 11'd0;
                  afits_in  = 1'b1;
               end
            end
            default: begin
               if (drem_ff != 11'd0) begin
                  tx_req      = '{wr_en: 1'b0, rd_en: 1'b1, addr: dpos_ff, wdata: 8'h00};
                  res.tx_valid = 1'b1;
                  res.tx_last  = (drem_ff == 11'd1);
                  dpos_in      = dpos_ff + 16'd1;
                  drem_in      = drem_ff - 11'd1;
               end
            end
         endcase
      end
   end

   // RX ring port: pending length bytes take priority
   always_comb begin
      if (busy) begin
         rx_req = '{wr_en: 1'b1, rd_en: 1'b0,
                    addr: (hcnt_ff == 2'd2) ? haddr_ff : haddr_ff + 16'd1,
                    wdata: (hcnt_ff == 2'd2) ? hlen_ff[15:8] : hlen_ff[7:0]};
      end else begin
         rx_req = rx_item_req;
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff     <= 1'b0;
         phase_ff   <= 2'd0;
         addr_ff    <= 16'd0;
         blk_ff     <= BLK_COMMON;
         wr_ff      <= 1'b0;
         station_ff <= '{default: 8'h00};
         smode_ff   <= 8'h00;
         sstat_ff   <= STATUS_NONE;
         txwr_ff    <= 16'd0;
         txrd_ff    <= 16'd0;
         rxwr_ff    <= 16'd0;
         rxrd_ff    <= 16'd0;
         acount_ff  <= 11'd0;
         afits_ff   <= 1'b1;
         dpos_ff    <= 16'd0;
         drem_ff    <= 11'd0;
         hcnt_ff    <= 2'd0;
      end else begin
         sel_ff     <= sel_in;
         phase_ff   <= phase_in;
         addr_ff    <= addr_in;
         blk_ff     <= blk_in;
         wr_ff      <= wr_in;
         station_ff <= station_in;
         smode_ff   <= smode_in;
         sstat_ff   <= sstat_in;
         txwr_ff    <= txwr_in;
         txrd_ff    <= txrd_in;
         rxwr_ff    <= rxwr_in;
         rxrd_ff    <= rxrd_in;
         acount_ff  <= acount_in;
         afits_ff   <= afits_in;
         dpos_ff    <= dpos_in;
         drem_ff    <= drem_in;
         hcnt_ff    <= hcnt_in;
      end
      haddr_ff <= haddr_in;
      hlen_ff  <= hlen_in;
   end

endmodule

>>> hw/rtl/spi_raw_ethernet_socket_core.sv
`timescale 1ns / 1ps

// Channel | Direction | Handshake            | Payload
// req     | in        | req_valid/req_stall  | mode, select_level, spi_in, net_byte, net_last
// rsp     | out       | rsp_valid/rsp_stall  | spi_out, tx_valid, tx_byte, tx_last, rx_dropped
//
// One beat per cycle unless stalled or busy; a result passes through the input
// register, then the result register with the ring read data.
// The end of a published network frame writes its two length bytes through
// the single RX ring write port, holding the request side while they are written.
// Synchronous reset clears all control state; ring contents are not cleared.
// A stalled result holds the pipeline; the input register still takes one beat.

module spi_raw_ethernet_socket_core import srs_pkg::*; #(
   parameter int RING_BYTES      = RING_BYTES_DEF,
   parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_mode,
   input  logic       req_select_level,
   input  logic [7:0] req_spi_in,
   input  logic [7:0] req_net_byte,
   input  logic       req_net_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_spi_out,
   output logic       rsp_tx_valid,
   output logic [7:0] rsp_tx_byte,
   output logic       rsp_tx_last,
   output logic       rsp_rx_dropped
);

   logic        a_valid_ff;
   item_type    a_item_ff;
   logic        b_valid_ff;
   result_type  b_res_ff;
   logic        fire, busy, accept, out_free;
   result_type  res;
   mem_req_type tx_req, rx_req;
   logic [7:0]  tx_q, rx_q;

   assign out_free  = !b_valid_ff || !rsp_stall;
   assign fire      = a_valid_ff && out_free && !busy;
   assign req_stall = a_valid_ff && !fire;
   assign accept    = req_valid && !req_stall;

   srs_core #(
      .RING_BYTES      (RING_BYTES),
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (a_item_ff),
      .res    (res),
      .tx_req (tx_req),
      .rx_req (rx_req),
      .busy   (busy)
   );

   srs_ring #(.DEPTH(RING_BYTES)) u_tx_ring (
      .clock   (clock),
      .req     (tx_req),
      .rd_data (tx_q)
   );

   srs_ring #(.DEPTH(RING_BYTES)) u_rx_ring (
      .clock   (clock),
      .req     (rx_req),
      .rd_data (rx_q)
   );

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (accept) begin
         a_valid_ff <= 1'b1;
      end else if (fire) begin
         a_valid_ff <= 1'b0;
      end
      if (accept) begin
         a_item_ff <= '{kind: kind_type'(req_mode), select_level: req_select_level,
                        spi_in: req_spi_in, net_byte: req_net_byte,
                        net_last: req_net_last};
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (fire) begin
         b_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         b_valid_ff <= 1'b0;
      end
      if (fire) begin
         b_res_ff <= res;
      end
   end

   assign rsp_valid      = b_valid_ff;
   assign rsp_spi_out    = b_res_ff.spi_from_mem ? rx_q : b_res_ff.spi_out;
   assign rsp_tx_valid   = b_res_ff.tx_valid;
   assign rsp_tx_byte    = b_res_ff.tx_valid ? tx_q : 8'h00;
   assign rsp_tx_last    = b_res_ff.tx_last;
   assign rsp_rx_dropped = b_res_ff.rx_dropped;

   // Checks
   a_no_fire_when_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !fire) else $error("item processed while length bytes pending");

   a_held_item_kept: assert property (@(posedge clock) disable iff (reset)
      (a_valid_ff && !fire) |=> a_valid_ff) else $error("held item lost");

   a_read_data_held: assert property (@(posedge clock) disable iff (reset)
      (b_valid_ff && rsp_stall) |=> ($stable(rx_q) && $stable(tx_q)))
      else $error("ring read data changed under stalled result");

   a_last_needs_valid: assert property (@(posedge clock) disable iff (reset)
      (b_valid_ff && b_res_ff.tx_last) |-> b_res_ff.tx_valid)
      else $error("tx_last without tx_valid");

   a_mem_only_for_spi: assert property (@(posedge clock) disable iff (reset)
      (fire && res.spi_from_mem) |-> (rx_req.rd_en && !rx_req.wr_en))
      else $error("rx ring read not issued for spi read");

endmodule
